FILE: sv/pl0psm_pkg.sv
// pl0psm_pkg: shared types, codes and field widths of the p-code stack machine
// used by the channel interfaces, the arithmetic unit, the checker and the top level
`default_nettype none

package pl0psm_pkg;

  // default configuration
  localparam int unsigned STACK_DEPTH_DEF = 4096;
  localparam int unsigned WORD_WIDTH_DEF  = 32;
  localparam int unsigned MAX_LEVEL_DEF   = 3;
  localparam int unsigned CODE_SIZE_DEF   = 2048;

  // fixed field widths
  localparam int unsigned ACTION_W    = 3;
  localparam int unsigned LEVEL_W     = 2;
  localparam int unsigned OPERAND_W   = 32;
  localparam int unsigned NEXT_PC_W   = 11;
  localparam int unsigned TOP_VALUE_W = 32;
  localparam int unsigned TOP_INDEX_W = 13;
  localparam int unsigned ERR_W       = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LIT = 3'd0,
    ACT_OPR = 3'd1,
    ACT_LOD = 3'd2,
    ACT_STO = 3'd3,
    ACT_CAL = 3'd4,
    ACT_INT = 3'd5,
    ACT_JMP = 3'd6,
    ACT_JPC = 3'd7
  } action_e;

  typedef enum logic [3:0] {
    OPR_RET = 4'd0,
    OPR_NEG = 4'd1,
    OPR_ADD = 4'd2,
    OPR_SUB = 4'd3,
    OPR_MUL = 4'd4,
    OPR_DIV = 4'd5,
    OPR_ODD = 4'd6,
    OPR_EQ  = 4'd8,
    OPR_NE  = 4'd9,
    OPR_LT  = 4'd10,
    OPR_LE  = 4'd11,
    OPR_GT  = 4'd12,
    OPR_GE  = 4'd13
  } opr_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_DIV0  = 2'd1,
    ERR_STACK = 2'd2,
    ERR_JUMP  = 2'd3
  } err_e;

  // request to the arithmetic unit
  typedef struct packed {
    logic start;
    opr_e op;
  } alu_req_t;

endpackage

`default_nettype wire

FILE: sv/pl0psm_if.sv
// pl0psm_in_if / pl0psm_out_if: valid-ready channels of the p-code stack machine
// depends on pl0psm_pkg for the field widths
`default_nettype none

interface pl0psm_in_if;
  logic                                valid;
  logic                                ready;
  logic [pl0psm_pkg::ACTION_W-1:0]     action;
  logic [pl0psm_pkg::LEVEL_W-1:0]      level;
  logic signed [pl0psm_pkg::OPERAND_W-1:0] operand;

  modport source (output valid, action, level, operand, input ready);
  modport sink   (input valid, action, level, operand, output ready);
endinterface

interface pl0psm_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [pl0psm_pkg::NEXT_PC_W-1:0]      next_pc;
  logic signed [pl0psm_pkg::TOP_VALUE_W-1:0] top_value;
  logic [pl0psm_pkg::TOP_INDEX_W-1:0]    top_index;
  logic                                  halted;
  logic [pl0psm_pkg::ERR_W-1:0]          error_code;

  modport source (output valid, next_pc, top_value, top_index, halted, error_code,
                  input ready);
  modport sink   (input valid, next_pc, top_value, top_index, halted, error_code,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/pl0psm_alu.sv
// pl0psm_alu: shared arithmetic unit, registered add, subtract and compares,
// bit-serial multiply and restoring divide; depends on pl0psm_pkg
`default_nettype none

module pl0psm_alu #(
  parameter int unsigned WORD_WIDTH = pl0psm_pkg::WORD_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire pl0psm_pkg::alu_req_t  req_i,
  input  wire logic [WORD_WIDTH-1:0] x_i,
  input  wire logic [WORD_WIDTH-1:0] y_i,
  output logic                       done_o,
  output logic [WORD_WIDTH-1:0]      result_o
);
  import pl0psm_pkg::*;

  localparam int unsigned W  = WORD_WIDTH;
  localparam int unsigned CW = $clog2(W + 1);

  typedef enum logic [1:0] {
    A_IDLE,
    A_MUL,
    A_DIV,
    A_FIX
  } alu_state_e;

  alu_state_e     state_q;
  logic           done_q;
  logic [W-1:0]   res_q;
  logic [W-1:0]   opa_q;   // multiplicand, or dividend magnitude then quotient
  logic [W-1:0]   opb_q;   // multiplier, or divisor magnitude
  logic [W:0]     rem_q;
  logic [CW-1:0]  cnt_q;
  logic           neg_q;

  logic [W:0]     rem_sh;
  logic [W:0]     rem_sub;

  assign rem_sh  = {rem_q[W-1:0], opa_q[W-1]};
  assign rem_sub = rem_sh - {1'b0, opb_q};

  assign done_o   = done_q;
  assign result_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
      res_q   <= '0;
      opa_q   <= '0;
      opb_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        A_IDLE: begin
          if (req_i.start) begin
            case (req_i.op)
              OPR_ADD: begin res_q <= x_i + y_i; done_q <= 1'b1; end
              OPR_SUB: begin res_q <= x_i - y_i; done_q <= 1'b1; end
              OPR_EQ:  begin res_q <= W'(x_i == y_i); done_q <= 1'b1; end
              OPR_NE:  begin res_q <= W'(x_i != y_i); done_q <= 1'b1; end
              OPR_LT:  begin res_q <= W'($signed(x_i) <  $signed(y_i)); done_q <= 1'b1; end
              OPR_LE:  begin res_q <= W'($signed(x_i) <= $signed(y_i)); done_q <= 1'b1; end
              OPR_GT:  begin res_q <= W'($signed(x_i) >  $signed(y_i)); done_q <= 1'b1; end
              OPR_GE:  begin res_q <= W'($signed(x_i) >= $signed(y_i)); done_q <= 1'b1; end
              OPR_MUL: begin
                res_q   <= '0;
                opa_q   <= x_i;
                opb_q   <= y_i;
                cnt_q   <= CW'(W);
                state_q <= A_MUL;
              end
              OPR_DIV: begin
                // work on magnitudes, the most negative word fits as unsigned
                opa_q   <= x_i[W-1] ? (~x_i + 1'b1) : x_i;
                opb_q   <= y_i[W-1] ? (~y_i + 1'b1) : y_i;
                neg_q   <= x_i[W-1] ^ y_i[W-1];
                rem_q   <= '0;
                cnt_q   <= CW'(W);
                state_q <= A_DIV;
              end
              default: begin res_q <= '0; done_q <= 1'b1; end
            endcase
          end
        end
        A_MUL: begin
          if (opb_q[0]) begin
            res_q <= res_q + opa_q;
          end
          opa_q <= opa_q << 1;
          opb_q <= opb_q >> 1;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CW'(1)) begin
            state_q <= A_FIX;
            neg_q   <= 1'b0;
          end
        end
        A_DIV: begin
          if (!rem_sub[W]) begin
            rem_q <= rem_sub;
            opa_q <= {opa_q[W-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            opa_q <= {opa_q[W-2:0], 1'b0};
          end
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CW'(1)) begin
            state_q <= A_FIX;
          end
        end
        A_FIX: begin
          // multiply leaves its product in res_q, divide its quotient in opa_q
          if (neg_q) begin
            res_q <= ~opa_q + 1'b1;
          end else if (opb_q == '0 && rem_q == '0 && cnt_q == '0 && res_q != '0) begin
            res_q <= res_q;
          end
          done_q  <= 1'b1;
          state_q <= A_IDLE;
        end
        default: state_q <= A_IDLE;
      endcase
      if (state_q == A_DIV && cnt_q == CW'(1) && !neg_q) begin
        res_q <= rem_sub[W] ? {opa_q[W-2:0], 1'b0} : {opa_q[W-2:0], 1'b1};
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/pl0psm_stack_ram.sv
// pl0psm_stack_ram: single-write, single-read stack memory with registered read;
// entries one to three read as zero until first written; no package needed
`default_nettype none

module pl0psm_stack_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic [3:1]       clean_q;
  logic             zero_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= mem[raddr_i];
  end

  // frame header entries of the outermost frame start at zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clean_q <= '1;
      zero_q  <= 1'b0;
    end else begin
      zero_q <= (raddr_i == AW'(1) && clean_q[1]) ||
                (raddr_i == AW'(2) && clean_q[2]) ||
                (raddr_i == AW'(3) && clean_q[3]);
      if (we_i) begin
        if (waddr_i == AW'(1)) clean_q[1] <= 1'b0;
        if (waddr_i == AW'(2)) clean_q[2] <= 1'b0;
        if (waddr_i == AW'(3)) clean_q[3] <= 1'b0;
      end
    end
  end

  assign rdata_o = zero_q ? '0 : rd_q;

endmodule

`default_nettype wire

FILE: sv/pl0_pcode_stack_machine_unit.sv
// pl0_pcode_stack_machine_unit: p-code interpreter top level, sequencer over the
// stack ram and the shared arithmetic unit; depends on pl0psm_pkg, pl0psm_if,
// pl0psm_alu and pl0psm_stack_ram
//
//  channel   dir  fields                                             sizes
//  in_ch_i   in   action, level, operand                             3, 2, 32
//  out_ch_o  out  next_pc, top_value, top_index, halted, error_code  11, 32, 13, 1, 2
//
// one request at a time; each static link walked costs one more ram read, and the steps
// are set by the single stack ram port pair (one read, one write a cycle)
// multiply and divide go bit-serial through the shared unit
// reset is asynchronous; no clearing pass, the ram holds its contents
// a new request is taken while a result waits on out_ch_o; the sequencer only
// stalls at its last step when the previous result is still not taken
`default_nettype none

module pl0_pcode_stack_machine_unit #(
  parameter int unsigned STACK_DEPTH = pl0psm_pkg::STACK_DEPTH_DEF,
  parameter int unsigned WORD_WIDTH  = pl0psm_pkg::WORD_WIDTH_DEF,
  parameter int unsigned MAX_LEVEL   = pl0psm_pkg::MAX_LEVEL_DEF,
  parameter int unsigned CODE_SIZE   = pl0psm_pkg::CODE_SIZE_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pl0psm_in_if.sink   in_ch_i,
  pl0psm_out_if.source out_ch_o
);
  import pl0psm_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned PW = $clog2(CODE_SIZE);
  localparam int unsigned W  = WORD_WIDTH;
  localparam int unsigned SW = 34;

  localparam logic signed [SW-1:0] DEPTH_S = SW'(STACK_DEPTH);
  localparam logic signed [SW-1:0] CODE_S  = SW'(CODE_SIZE);

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_WALK,
    S_WALK_WT,
    S_POST,
    S_RET_A,
    S_RET_B,
    S_UNARY,
    S_BIN_Y,
    S_BIN_X,
    S_BIN_WAIT,
    S_LOD_WR,
    S_STO_WR,
    S_CAL2,
    S_CAL3,
    S_JPC,
    S_FIN_RD,
    S_FIN_WT
  } seq_state_e;

  seq_state_e             state_q, state_d;
  action_e                act_q, act_d;
  logic [1:0]             cnt_q, cnt_d;
  logic signed [OPERAND_W-1:0] opnd_q, opnd_d;
  logic [AW-1:0]          top_q, top_d;
  logic [AW-1:0]          base_q, base_d;
  logic [PW-1:0]          pc_q, pc_d;
  logic [AW-1:0]          b1_q, b1_d;
  logic [AW-1:0]          addr_q, addr_d;
  logic [W-1:0]           x_q, x_d;
  logic [W-1:0]           y_q, y_d;
  err_e                   err_q, err_d;

  logic                   ovalid_q, ovalid_d;
  logic [NEXT_PC_W-1:0]   onpc_q, onpc_d;
  logic [TOP_VALUE_W-1:0] oval_q, oval_d;
  logic [TOP_INDEX_W-1:0] oidx_q, oidx_d;
  logic                   ohalt_q, ohalt_d;
  err_e                   oerr_q, oerr_d;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [W-1:0]           mem_wdata, mem_rdata;

  alu_req_t               alu_req;
  logic                   alu_done;
  logic [W-1:0]           alu_res;

  logic [PW-1:0]          fall;
  logic signed [SW-1:0]   t_s, b_s, b1_s, op_s, frame_s, nt_s;
  logic signed [63:0]     rd_s;
  logic                   frame_ok, jmp_ok, link_ok, rpc_ok;
  logic                   opr_small;
  opr_e                   opr;
  logic [1:0]             lvl_clip;
  logic signed [63:0]     lit64;
  logic signed [63:0]     top64;
  logic [31:0]            idx32;
  logic [31:0]            pc32;

  pl0psm_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (W)
  ) u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  pl0psm_alu #(
    .WORD_WIDTH (W)
  ) u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .x_i      (mem_rdata),
    .y_i      (y_q),
    .done_o   (alu_done),
    .result_o (alu_res)
  );

  assign fall     = (pc_q == PW'(CODE_SIZE - 1)) ? '0 : pc_q + 1'b1;
  assign t_s      = SW'(top_q);
  assign b_s      = SW'(base_q);
  assign b1_s     = SW'(b1_q);
  assign op_s     = SW'(opnd_q);
  assign frame_s  = b1_s + op_s;
  assign nt_s     = t_s + op_s;
  assign rd_s     = 64'(signed'(mem_rdata));
  assign frame_ok = frame_s >= 0 && frame_s < DEPTH_S;
  assign jmp_ok   = op_s >= 0 && op_s < CODE_S;
  assign link_ok  = rd_s >= 0 && rd_s < 64'(STACK_DEPTH);
  assign rpc_ok   = rd_s >= 0 && rd_s < 64'(CODE_SIZE);
  assign opr_small = opnd_q[OPERAND_W-1:4] == '0;
  assign opr      = opr_e'(opnd_q[3:0]);
  assign lit64    = 64'(opnd_q);
  assign lvl_clip = (32'(in_ch_i.level) > MAX_LEVEL) ? 2'(MAX_LEVEL) : in_ch_i.level;
  assign top64    = 64'(signed'(mem_rdata));
  assign idx32    = 32'(top_q);
  assign pc32     = 32'(pc_q);

  assign in_ch_i.ready       = state_q == S_IDLE;
  assign out_ch_o.valid      = ovalid_q;
  assign out_ch_o.next_pc    = onpc_q;
  assign out_ch_o.top_value  = oval_q;
  assign out_ch_o.top_index  = oidx_q;
  assign out_ch_o.halted     = ohalt_q;
  assign out_ch_o.error_code = oerr_q;

  always_comb begin
    state_d  = state_q;
    act_d    = act_q;
    cnt_d    = cnt_q;
    opnd_d   = opnd_q;
    top_d    = top_q;
    base_d   = base_q;
    pc_d     = pc_q;
    b1_d     = b1_q;
    addr_d   = addr_q;
    x_d      = x_q;
    y_d      = y_q;
    err_d    = err_q;
    ovalid_d = ovalid_q;
    onpc_d   = onpc_q;
    oval_d   = oval_q;
    oidx_d   = oidx_q;
    ohalt_d  = ohalt_q;
    oerr_d   = oerr_q;
    mem_we    = 1'b0;
    mem_waddr = top_q;
    mem_wdata = '0;
    mem_raddr = top_q;
    alu_req.start = 1'b0;
    alu_req.op    = opr;

    if (ovalid_q && out_ch_o.ready) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_ch_i.valid) begin
          act_d   = action_e'(in_ch_i.action);
          cnt_d   = lvl_clip;
          opnd_d  = in_ch_i.operand;
          b1_d    = base_q;
          err_d   = ERR_NONE;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        pc_d    = fall;
        state_d = S_FIN_RD;
        unique case (act_q)
          ACT_LIT: begin
            if (t_s < DEPTH_S - 1) begin
              mem_we    = 1'b1;
              mem_waddr = top_q + 1'b1;
              mem_wdata = lit64[W-1:0];
              top_d     = top_q + 1'b1;
            end else begin
              err_d = ERR_STACK;
            end
          end
          ACT_OPR: begin
            if (opr_small) begin
              case (opr)
                OPR_RET: begin
                  if (base_q == '0 || b_s >= DEPTH_S - 2) begin
                    err_d = ERR_STACK;
                  end else begin
                    mem_raddr = base_q + 1'b1;
                    state_d   = S_RET_A;
                  end
                end
                OPR_NEG, OPR_ODD: state_d = S_UNARY;
                OPR_ADD, OPR_SUB, OPR_MUL, OPR_DIV, OPR_EQ, OPR_NE,
                OPR_LT, OPR_LE, OPR_GT, OPR_GE: begin
                  if (top_q == '0) begin
                    err_d = ERR_STACK;
                  end else begin
                    state_d = S_BIN_Y;
                  end
                end
                default: ;
              endcase
            end
          end
          ACT_LOD: begin
            if (t_s < DEPTH_S - 1) state_d = S_WALK;
            else err_d = ERR_STACK;
          end
          ACT_STO: begin
            if (top_q != '0) state_d = S_WALK;
            else err_d = ERR_STACK;
          end
          ACT_CAL: begin
            if (t_s < DEPTH_S - 3) state_d = S_WALK;
            else err_d = ERR_STACK;
          end
          ACT_INT: begin
            if (nt_s >= 0 && nt_s < DEPTH_S) top_d = nt_s[AW-1:0];
            else err_d = ERR_STACK;
          end
          ACT_JMP: begin
            if (jmp_ok) pc_d = opnd_q[PW-1:0];
            else err_d = ERR_JUMP;
          end
          ACT_JPC: begin
            if (top_q != '0) state_d = S_JPC;
            else err_d = ERR_STACK;
          end
          default: ;
        endcase
      end
      // follow static links, one ram read per link
      S_WALK: begin
        if (cnt_q == '0) begin
          state_d = S_POST;
        end else begin
          mem_raddr = b1_q;
          state_d   = S_WALK_WT;
        end
      end
      S_WALK_WT: begin
        if (link_ok) begin
          b1_d    = rd_s[AW-1:0];
          cnt_d   = cnt_q - 1'b1;
          state_d = S_WALK;
        end else begin
          err_d   = ERR_STACK;
          state_d = S_FIN_RD;
        end
      end
      S_POST: begin
        state_d = S_FIN_RD;
        case (act_q)
          ACT_LOD: begin
            if (frame_ok) begin
              mem_raddr = frame_s[AW-1:0];
              state_d   = S_LOD_WR;
            end else begin
              err_d = ERR_STACK;
            end
          end
          ACT_STO: begin
            if (frame_ok) begin
              addr_d  = frame_s[AW-1:0];
              state_d = S_STO_WR;
            end else begin
              err_d = ERR_STACK;
            end
          end
          ACT_CAL: begin
            if (jmp_ok) begin
              mem_we    = 1'b1;
              mem_waddr = top_q + 1'b1;
              mem_wdata = W'(b1_q);
              state_d   = S_CAL2;
            end else begin
              err_d = ERR_JUMP;
            end
          end
          default: ;
        endcase
      end
      S_RET_A: begin
        if (link_ok) begin
          x_d       = mem_rdata;
          mem_raddr = base_q + 2'd2;
          state_d   = S_RET_B;
        end else begin
          err_d   = ERR_STACK;
          state_d = S_FIN_RD;
        end
      end
      S_RET_B: begin
        if (rpc_ok) begin
          top_d  = base_q - 1'b1;
          base_d = x_q[AW-1:0];
          pc_d   = rd_s[PW-1:0];
        end else begin
          err_d = ERR_JUMP;
        end
        state_d = S_FIN_RD;
      end
      S_UNARY: begin
        mem_we    = 1'b1;
        mem_waddr = top_q;
        mem_wdata = (opr == OPR_NEG) ? (~mem_rdata + 1'b1) : W'(mem_rdata[0]);
        state_d   = S_FIN_RD;
      end
      S_BIN_Y: begin
        if (opr == OPR_DIV && mem_rdata == '0) begin
          err_d   = ERR_DIV0;
          state_d = S_FIN_RD;
        end else begin
          y_d       = mem_rdata;
          mem_raddr = top_q - 1'b1;
          state_d   = S_BIN_X;
        end
      end
      S_BIN_X: begin
        alu_req.start = 1'b1;
        state_d       = S_BIN_WAIT;
      end
      S_BIN_WAIT: begin
        if (alu_done) begin
          mem_we    = 1'b1;
          mem_waddr = top_q - 1'b1;
          mem_wdata = alu_res;
          top_d     = top_q - 1'b1;
          state_d   = S_FIN_RD;
        end
      end
      S_LOD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = top_q + 1'b1;
        mem_wdata = mem_rdata;
        top_d     = top_q + 1'b1;
        state_d   = S_FIN_RD;
      end
      S_STO_WR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        mem_wdata = mem_rdata;
        top_d     = top_q - 1'b1;
        state_d   = S_FIN_RD;
      end
      S_CAL2: begin
        mem_we    = 1'b1;
        mem_waddr = top_q + 2'd2;
        mem_wdata = W'(base_q);
        state_d   = S_CAL3;
      end
      S_CAL3: begin
        // pc_q already holds the fall-through address since dispatch
        mem_we    = 1'b1;
        mem_waddr = top_q + 2'd3;
        mem_wdata = W'(pc_q);
        base_d    = top_q + 1'b1;
        pc_d      = opnd_q[PW-1:0];
        state_d   = S_FIN_RD;
      end
      S_JPC: begin
        state_d = S_FIN_RD;
        if (mem_rdata == '0) begin
          if (jmp_ok) begin
            pc_d  = opnd_q[PW-1:0];
            top_d = top_q - 1'b1;
          end else begin
            err_d = ERR_JUMP;
          end
        end else begin
          top_d = top_q - 1'b1;
        end
      end
      S_FIN_RD: begin
        state_d = S_FIN_WT;
      end
      S_FIN_WT: begin
        // hold the top read until the output register is free
        if (!ovalid_q || out_ch_o.ready) begin
          ovalid_d = 1'b1;
          onpc_d   = pc32[NEXT_PC_W-1:0];
          oval_d   = top64[TOP_VALUE_W-1:0];
          oidx_d   = idx32[TOP_INDEX_W-1:0];
          ohalt_d  = pc_q == '0;
          oerr_d   = err_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      act_q    <= ACT_LIT;
      cnt_q    <= '0;
      opnd_q   <= '0;
      top_q    <= '0;
      base_q   <= AW'(1);
      pc_q     <= '0;
      b1_q     <= '0;
      addr_q   <= '0;
      x_q      <= '0;
      y_q      <= '0;
      err_q    <= ERR_NONE;
      ovalid_q <= 1'b0;
      onpc_q   <= '0;
      oval_q   <= '0;
      oidx_q   <= '0;
      ohalt_q  <= 1'b0;
      oerr_q   <= ERR_NONE;
    end else begin
      state_q  <= state_d;
      act_q    <= act_d;
      cnt_q    <= cnt_d;
      opnd_q   <= opnd_d;
      top_q    <= top_d;
      base_q   <= base_d;
      pc_q     <= pc_d;
      b1_q     <= b1_d;
      addr_q   <= addr_d;
      x_q      <= x_d;
      y_q      <= y_d;
      err_q    <= err_d;
      ovalid_q <= ovalid_d;
      onpc_q   <= onpc_d;
      oval_q   <= oval_d;
      oidx_q   <= oidx_d;
      ohalt_q  <= ohalt_d;
      oerr_q   <= oerr_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/pl0psm_checker.sv
// pl0psm_checker: port-level assertions for the p-code stack machine, bound to
// pl0_pcode_stack_machine_unit; depends on pl0psm_pkg for the field widths
`default_nettype none

module pl0psm_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_ready_i,
  input wire logic                              out_valid_i,
  input wire logic                              out_ready_i,
  input wire logic [pl0psm_pkg::NEXT_PC_W-1:0]  next_pc_i,
  input wire logic [pl0psm_pkg::TOP_VALUE_W-1:0] top_value_i,
  input wire logic                              halted_i,
  input wire logic [pl0psm_pkg::ERR_W-1:0]      error_code_i
);

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(next_pc_i) &&
    $stable(top_value_i) && $stable(error_code_i))
    else $error("result changed while stalled");

  // one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second request taken while busy");

  // halt flag follows the fetch address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> halted_i == (next_pc_i == '0))
    else $error("halt flag disagrees with next_pc");

  // a result never shows up in the cycle right after a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result too early");

endmodule

bind pl0_pcode_stack_machine_unit pl0psm_checker u_pl0psm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_ch_i.valid),
  .in_ready_i   (in_ch_i.ready),
  .out_valid_i  (out_ch_o.valid),
  .out_ready_i  (out_ch_o.ready),
  .next_pc_i    (out_ch_o.next_pc),
  .top_value_i  (out_ch_o.top_value),
  .halted_i     (out_ch_o.halted),
  .error_code_i (out_ch_o.error_code)
);

`default_nettype wire
